// File: rtl/core/rob_pkg.sv
// ----------------------------------------------------------------------------
// rob_pkg
// Shared types and codes of the reorder buffer: operation and status codes,
// channel payloads, stored entry layout and per-item bookkeeping.
// ----------------------------------------------------------------------------
package rob_pkg;

	localparam int unsigned DEPTH_DEF = 80;
	localparam int unsigned VALUE_W   = 33;  // result value plus mispredict flag

	typedef enum logic [2:0] {
		FN_ALLOC    = 3'd0,
		FN_WRITE    = 3'd1,
		FN_COMMIT   = 3'd2,
		FN_ROLLBACK = 3'd3,
		FN_READ     = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_FULL    = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_NOTDONE = 3'd3,
		ST_BADIDX  = 3'd4
	} status_t;

	typedef struct packed {
		logic [2:0]  func;
		logic [6:0]  slot;
		logic [31:0] pc;
		logic [5:0]  instr_kind;
		logic [4:0]  arch_dest;
		logic [5:0]  phys_dest;
		logic [5:0]  prior_phys;
		logic [3:0]  branch_tag;
		logic [31:0] result_value;
		logic        mispredict_in;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [6:0]  slot_out;
		logic [31:0] pc_out;
		logic [5:0]  kind_out;
		logic [4:0]  arch_out;
		logic [5:0]  phys_out;
		logic [5:0]  prior_out;
		logic [3:0]  tag_out;
		logic [31:0] value_out;
		logic        done_out;
		logic        mispredict_out;
		logic [6:0]  occupancy;
	} rsp_t;

	// 59-bit static part of an entry, written at allocate
	typedef struct packed {
		logic [3:0]  tag;
		logic [5:0]  prior;
		logic [5:0]  phys;
		logic [4:0]  arch;
		logic [5:0]  kind;
		logic [31:0] pc;
	} entry_t;

	// what the response stage needs besides the memory read data
	typedef struct packed {
		status_t    status;
		logic [6:0] slot_out;
		logic [6:0] occupancy;
		logic       emit;
		logic       done;
	} meta_t;

endpackage

// File: rtl/core/rob_if.sv
// ----------------------------------------------------------------------------
// rob_if
// Valid/ready channels of the reorder buffer: operation requests and
// responses.
// ----------------------------------------------------------------------------
interface rob_req_if;
	logic          valid;
	logic          ready;
	rob_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rob_rsp_if;
	logic          valid;
	logic          ready;
	rob_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/rob_store.sv
// ----------------------------------------------------------------------------
// rob_store
// Entry storage: payload memory and value memory, one write port each and a
// shared read address with registered read data.
// ----------------------------------------------------------------------------
module rob_store #(
	parameter int unsigned DEPTH = rob_pkg::DEPTH_DEF,
	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                             clk,
	input  logic                             pl_we,
	input  logic [IDX_W-1:0]                 pl_waddr,
	input  rob_pkg::entry_t                  pl_wdata,
	input  logic                             vl_we,
	input  logic [IDX_W-1:0]                 vl_waddr,
	input  logic [rob_pkg::VALUE_W-1:0]      vl_wdata,
	input  logic                             rd_en,
	input  logic [IDX_W-1:0]                 rd_addr,
	output rob_pkg::entry_t                  pl_rdata,
	output logic [rob_pkg::VALUE_W-1:0]      vl_rdata
);

	rob_pkg::entry_t                  pl_mem [DEPTH];
	logic [rob_pkg::VALUE_W-1:0]      vl_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (pl_we) begin
			pl_mem[pl_waddr] <= pl_wdata;
		end
		if (rd_en) begin
			pl_rdata <= pl_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (vl_we) begin
			vl_mem[vl_waddr] <= vl_wdata;
		end
		if (rd_en) begin
			vl_rdata <= vl_mem[rd_addr];
		end
	end

endmodule

// File: rtl/core/rob_ctrl.sv
// ----------------------------------------------------------------------------
// rob_ctrl
// Pointer, count and per-entry flag logic. Decodes each accepted item,
// updates head, tail, count, live and completed flags, and drives the
// memory ports.
// ----------------------------------------------------------------------------
module rob_ctrl #(
	parameter int unsigned DEPTH = rob_pkg::DEPTH_DEF,
	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  rob_pkg::req_t                    req,
	output rob_pkg::meta_t                   meta,
	output logic                             pl_we,
	output logic [IDX_W-1:0]                 pl_waddr,
	output rob_pkg::entry_t                  pl_wdata,
	output logic                             vl_we,
	output logic [IDX_W-1:0]                 vl_waddr,
	output logic [rob_pkg::VALUE_W-1:0]      vl_wdata,
	output logic [IDX_W-1:0]                 rd_addr
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned DW    = IDX_W + 1;

	logic [IDX_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] count_q, count_nxt;
	logic [DEPTH-1:0] valid_q, done_q, kill;

	logic             slot_ok;
	logic [IDX_W-1:0] sidx, slot_dist;
	logic             alloc_ok, wr_ok, commit_ok, rb_ok;

	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] a);
		return (a == IDX_W'(DEPTH - 1)) ? '0 : a + IDX_W'(1);
	endfunction

	// (a - b) mod DEPTH
	function automatic logic [IDX_W-1:0] dist_of(input logic [IDX_W-1:0] a,
		input logic [IDX_W-1:0] b);
		logic [DW-1:0] t;
		t = {1'b0, a} + DW'(DEPTH) - {1'b0, b};
		if (t >= DW'(DEPTH)) begin
			t = t - DW'(DEPTH);
		end
		return t[IDX_W-1:0];
	endfunction

	assign slot_ok   = (32'(req.slot) < DEPTH);
	assign sidx      = IDX_W'(req.slot);
	assign slot_dist = dist_of(sidx, head_q);

	always_comb begin
		meta      = '0;
		alloc_ok  = 1'b0;
		wr_ok     = 1'b0;
		commit_ok = 1'b0;
		rb_ok     = 1'b0;
		count_nxt = count_q;
		case (req.func)
			rob_pkg::FN_ALLOC: begin
				if (count_q == CNT_W'(DEPTH)) begin
					meta.status = rob_pkg::ST_FULL;
				end else begin
					alloc_ok      = 1'b1;
					meta.slot_out = 7'(tail_q);
					count_nxt     = count_q + CNT_W'(1);
				end
			end
			rob_pkg::FN_WRITE: begin
				meta.slot_out = req.slot;
				if (!slot_ok) begin
					meta.status = rob_pkg::ST_BADIDX;
				end else begin
					wr_ok = valid_q[sidx];
				end
			end
			rob_pkg::FN_COMMIT: begin
				if (count_q == '0) begin
					meta.status = rob_pkg::ST_EMPTY;
				end else begin
					meta.slot_out = 7'(head_q);
					if (!done_q[head_q]) begin
						meta.status = rob_pkg::ST_NOTDONE;
					end else begin
						commit_ok = 1'b1;
						meta.emit = 1'b1;
						meta.done = 1'b1;
						count_nxt = count_q - CNT_W'(1);
					end
				end
			end
			rob_pkg::FN_ROLLBACK: begin
				meta.slot_out = req.slot;
				if (!slot_ok || CNT_W'(slot_dist) >= count_q) begin
					meta.status = rob_pkg::ST_BADIDX;
				end else begin
					rb_ok     = 1'b1;
					count_nxt = CNT_W'(slot_dist) + CNT_W'(1);
				end
			end
			rob_pkg::FN_READ: begin
				meta.slot_out = req.slot;
				if (!slot_ok) begin
					meta.status = rob_pkg::ST_BADIDX;
				end else begin
					meta.emit = valid_q[sidx];
					meta.done = done_q[sidx];
				end
			end
			default: begin
			end
		endcase
		meta.occupancy = 7'(count_nxt);
	end

	// entries past the rollback slot but still inside the live window
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			kill[i] = (dist_of(IDX_W'(i), head_q) > slot_dist)
				&& (CNT_W'(dist_of(IDX_W'(i), head_q)) < count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			valid_q <= '0;
			done_q  <= '0;
		end else if (accept) begin
			count_q <= count_nxt;
			if (alloc_ok) begin
				valid_q[tail_q] <= 1'b1;
				done_q[tail_q]  <= 1'b0;
				tail_q          <= wrap_inc(tail_q);
			end
			if (wr_ok) begin
				done_q[sidx] <= 1'b1;
			end
			if (commit_ok) begin
				valid_q[head_q] <= 1'b0;
				head_q          <= wrap_inc(head_q);
			end
			if (rb_ok) begin
				valid_q <= valid_q & ~kill;
				tail_q  <= wrap_inc(sidx);
			end
		end
	end

	assign pl_we    = accept && alloc_ok;
	assign pl_waddr = tail_q;
	assign pl_wdata = '{tag: req.branch_tag, prior: req.prior_phys, phys: req.phys_dest,
		arch: req.arch_dest, kind: req.instr_kind, pc: req.pc};

	// allocate clears the value and mispredict bit of the new entry
	assign vl_we    = accept && (alloc_ok || wr_ok);
	assign vl_waddr = alloc_ok ? tail_q : sidx;
	assign vl_wdata = alloc_ok ? '0 : {req.mispredict_in, req.result_value};

	assign rd_addr  = (req.func == rob_pkg::FN_COMMIT) ? head_q : (slot_ok ? sidx : '0);

endmodule

// File: rtl/core/reorder_buffer.sv
// ----------------------------------------------------------------------------
// reorder_buffer
// Circular reorder buffer: allocate, write result, commit, rollback and read
// of DEPTH entries, one response per request.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation per item (func selects it); rsp returns exactly
//   one result item per request, in request order, with status, slot,
//   occupancy after the operation and, for a good commit or a live read, the
//   entry fields.
//   The request cycle decodes and updates pointers and flags while the memory
//   read is issued; the read stage then merges the registered read data into
//   the output register, which drives rsp.valid. Throughput is one item per
//   cycle while rsp is not stalled, as every operation does its flag update
//   and its memory accesses in the cycle it is accepted.
//   A stalled rsp holds its item; one further request is taken and parked in
//   the read stage, after which req.ready drops until rsp drains.
//   Reset clears head, tail, count and the live and completed flags at once;
//   the entry memories need no clearing, so requests are taken right after
//   reset.
// ----------------------------------------------------------------------------
module reorder_buffer #(
	parameter int unsigned DEPTH = rob_pkg::DEPTH_DEF
) (
	input logic           clk,
	input logic           arst_n,
	rob_req_if.sink       req,
	rob_rsp_if.source     rsp
);

	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                         accept, adv;
	logic                         valid_s1, out_valid_q;
	rob_pkg::meta_t               meta, meta_s1;
	rob_pkg::rsp_t                rsp_q;

	logic                         pl_we, vl_we;
	logic [IDX_W-1:0]             pl_waddr, vl_waddr, rd_addr;
	rob_pkg::entry_t              pl_wdata, pl_rdata;
	logic [rob_pkg::VALUE_W-1:0]  vl_wdata, vl_rdata;

	assign adv       = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;
	assign accept    = req.valid && req.ready;

	rob_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.req      (req.data),
		.meta     (meta),
		.pl_we    (pl_we),
		.pl_waddr (pl_waddr),
		.pl_wdata (pl_wdata),
		.vl_we    (vl_we),
		.vl_waddr (vl_waddr),
		.vl_wdata (vl_wdata),
		.rd_addr  (rd_addr)
	);

	rob_store #(.DEPTH(DEPTH)) u_store (
		.clk      (clk),
		.pl_we    (pl_we),
		.pl_waddr (pl_waddr),
		.pl_wdata (pl_wdata),
		.vl_we    (vl_we),
		.vl_waddr (vl_waddr),
		.vl_wdata (vl_wdata),
		.rd_en    (accept),
		.rd_addr  (rd_addr),
		.pl_rdata (pl_rdata),
		.vl_rdata (vl_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			meta_s1 <= meta;
		end
		if (adv) begin
			rsp_q.status         <= meta_s1.status;
			rsp_q.slot_out       <= meta_s1.slot_out;
			rsp_q.occupancy      <= meta_s1.occupancy;
			rsp_q.done_out       <= meta_s1.emit & meta_s1.done;
			// entry fields only for a good commit or a read of a live entry
			rsp_q.pc_out         <= meta_s1.emit ? pl_rdata.pc : '0;
			rsp_q.kind_out       <= meta_s1.emit ? pl_rdata.kind : '0;
			rsp_q.arch_out       <= meta_s1.emit ? pl_rdata.arch : '0;
			rsp_q.phys_out       <= meta_s1.emit ? pl_rdata.phys : '0;
			rsp_q.prior_out      <= meta_s1.emit ? pl_rdata.prior : '0;
			rsp_q.tag_out        <= meta_s1.emit ? pl_rdata.tag : '0;
			rsp_q.value_out      <= meta_s1.emit ? vl_rdata[31:0] : '0;
			rsp_q.mispredict_out <= meta_s1.emit & vl_rdata[32];
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = rsp_q;

endmodule
